// ===== src/bsg_pkg.sv =====
`default_nettype none

package bsg_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 16;
    localparam int PIX_W      = 8;
    localparam int IMG_W_W    = 12;
    localparam int SAT_W      = 8;
    localparam int GAIN_W     = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int VOFS_W     = PIX_W + 1;
    localparam int PROD_W     = VOFS_W + GAIN_W;
    localparam int OUT_DATA_W = 2 * PIX_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    localparam logic [IMG_W_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [ROW_W-1:0]   HEIGHT_RST = 16'd480;
    localparam logic [SAT_W-1:0]   SAT_RST    = 8'd16;
    localparam logic [GAIN_W-1:0]  GAIN_RST   = 8'd4;

    typedef logic [COL_W-1:0]         col_t;
    typedef logic [ROW_W-1:0]         row_t;
    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic [VOFS_W-1:0]        vofs_t;
    typedef logic [PROD_W-1:0]        prod_t;
    typedef logic [FIFO_AW-1:0]       ptr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [PIX_W+1:0]  sdiff_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_SAT_LIMIT    = 2'd2,
        REG_BOOST_GAIN   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [IMG_W_W-1:0] image_width;
        logic [ROW_W-1:0]   image_height;
        logic [SAT_W-1:0]   saturation_limit;
        logic [GAIN_W-1:0]  boost_gain;
    } cfg_t;

    typedef struct packed {
        logic  valid;
        vofs_t vx;
        vofs_t vy;
        logic  zero;
        logic  emit_b;
        logic  fe_b;
    } calc_t;

    typedef struct packed {
        pix_t gx;
        pix_t gy;
        logic emit_b;
        logic fe_b;
    } item_t;

endpackage

`default_nettype wire

// ===== src/bsg_ram.sv =====
`default_nettype none

module bsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/bsg_scan.sv =====
`default_nettype none

module bsg_scan (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire bsg_pkg::pix_t  pixel,
    input  wire bsg_pkg::cfg_t  cfg,
    output logic                has_res,
    output bsg_pkg::calc_t      calc
);

    bsg_pkg::col_t  col_reg, col_next, col_cur, w_last, rd_addr, rd_addr_right;
    bsg_pkg::row_t  row_reg, row_next, h_last;
    bsg_pkg::pix_t  left_reg, left_next;
    bsg_pkg::pix_t  above, mid, right;
    bsg_pkg::calc_t calc_reg, calc_next;
    logic           last_col, last_row;

    function automatic bsg_pkg::vofs_t offset_clamp(
        input bsg_pkg::pix_t          a,
        input bsg_pkg::pix_t          b,
        input logic [bsg_pkg::SAT_W-1:0] s
    );
        bsg_pkg::sdiff_t d;
        bsg_pkg::sdiff_t sv;
        bsg_pkg::sdiff_t m;
        bsg_pkg::sdiff_t v;
        d  = $signed({2'b00, a}) - $signed({2'b00, b});
        sv = $signed({2'b00, s});
        m  = (d < sv) ? d : sv;
        v  = sv + m;
        return v[bsg_pkg::PIX_W+1] ? '0 : v[bsg_pkg::VOFS_W-1:0];
    endfunction

    always_comb
    begin
        if (cfg.image_width < 12'd3)
        begin
            w_last = bsg_pkg::col_t'(2);
        end
        else if (32'(cfg.image_width) > 32'(bsg_pkg::MAX_WIDTH))
        begin
            w_last = bsg_pkg::col_t'(bsg_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            w_last = bsg_pkg::col_t'(cfg.image_width - 12'd1);
        end
        h_last = (cfg.image_height < 16'd3) ? 16'd2 : (cfg.image_height - 16'd1);
    end

    assign col_cur  = (col_reg > w_last) ? w_last : col_reg;
    assign last_col = (col_cur == w_last);
    assign last_row = (row_reg >= h_last);
    assign has_res  = (row_reg != bsg_pkg::row_t'(1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : (row_reg + bsg_pkg::row_t'(1));
            end
            else
            begin
                col_next = col_cur + bsg_pkg::col_t'(1);
            end
        end
    end

    // fetch the entries of the next beat's column while this beat is taken
    assign rd_addr       = accept ? col_next : col_cur;
    assign rd_addr_right = rd_addr + bsg_pkg::col_t'(1);
    assign left_next     = accept ? mid : left_reg;

    always_comb
    begin
        calc_next.valid  = accept && has_res;
        calc_next.vx     = offset_clamp(right, left_reg, cfg.saturation_limit);
        calc_next.vy     = offset_clamp(pixel, above, cfg.saturation_limit);
        calc_next.zero   = (row_reg == '0) || (col_cur == '0) || last_col;
        calc_next.emit_b = last_row;
        calc_next.fe_b   = last_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
            calc_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= left_next;
            calc_reg <= calc_next;
        end
    end

    bsg_ram #(
        .WIDTH(bsg_pkg::PIX_W),
        .DEPTH(bsg_pkg::MAX_WIDTH)
    ) u_older (
        .clk  (clk),
        .we   (accept),
        .waddr(col_cur),
        .wdata(mid),
        .raddr(rd_addr),
        .rdata(above)
    );

    bsg_ram #(
        .WIDTH(bsg_pkg::PIX_W),
        .DEPTH(bsg_pkg::MAX_WIDTH)
    ) u_newer_mid (
        .clk  (clk),
        .we   (accept),
        .waddr(col_cur),
        .wdata(pixel),
        .raddr(rd_addr),
        .rdata(mid)
    );

    bsg_ram #(
        .WIDTH(bsg_pkg::PIX_W),
        .DEPTH(bsg_pkg::MAX_WIDTH)
    ) u_newer_right (
        .clk  (clk),
        .we   (accept),
        .waddr(col_cur),
        .wdata(pixel),
        .raddr(rd_addr_right),
        .rdata(right)
    );

    assign calc = calc_reg;

endmodule

`default_nettype wire

// ===== src/bsg_boost.sv =====
`default_nettype none

module bsg_boost (
    input  wire bsg_pkg::calc_t             calc,
    input  wire logic [bsg_pkg::GAIN_W-1:0] gain,
    output logic                            push,
    output bsg_pkg::item_t                  item
);

    bsg_pkg::prod_t px, py;

    assign px = bsg_pkg::prod_t'(calc.vx) * bsg_pkg::prod_t'(gain);
    assign py = bsg_pkg::prod_t'(calc.vy) * bsg_pkg::prod_t'(gain);

    always_comb
    begin
        item.gx     = (|px[bsg_pkg::PROD_W-1:bsg_pkg::PIX_W]) ? bsg_pkg::PIX_MAX
                                                              : px[bsg_pkg::PIX_W-1:0];
        item.gy     = (|py[bsg_pkg::PROD_W-1:bsg_pkg::PIX_W]) ? bsg_pkg::PIX_MAX
                                                              : py[bsg_pkg::PIX_W-1:0];
        if (calc.zero)
        begin
            item.gx = '0;
            item.gy = '0;
        end
        item.emit_b = calc.emit_b;
        item.fe_b   = calc.fe_b;
    end

    assign push = calc.valid;

endmodule

`default_nettype wire

// ===== src/bsg_outq.sv =====
`default_nettype none

module bsg_outq (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               reserve,
    input  wire logic                               push,
    input  wire bsg_pkg::item_t                     item,
    output logic                                    room,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [bsg_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    output logic                                    m_axis_tuser,
    output logic                                    m_axis_tlast
);

    bsg_pkg::item_t fifo_reg [bsg_pkg::FIFO_DEPTH];
    bsg_pkg::item_t head;
    bsg_pkg::ptr_t  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    bsg_pkg::cnt_t  cnt_reg, cnt_next, resv_reg, resv_next;
    logic           phase_reg, phase_next;
    logic           beat, item_done;

    assign head          = fifo_reg[rd_ptr_reg];
    assign m_axis_tvalid = (cnt_reg != '0);
    assign beat          = m_axis_tvalid && m_axis_tready;
    assign item_done     = beat && (phase_reg || !head.emit_b);
    assign room          = (resv_reg < bsg_pkg::cnt_t'(bsg_pkg::FIFO_DEPTH));

    assign m_axis_tdata  = phase_reg ? '0 : {head.gy, head.gx};
    assign m_axis_tuser  = phase_reg && head.fe_b;
    assign m_axis_tlast  = phase_reg || !head.emit_b;

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + bsg_pkg::ptr_t'(1)) : wr_ptr_reg;
        rd_ptr_next = item_done ? (rd_ptr_reg + bsg_pkg::ptr_t'(1)) : rd_ptr_reg;
        cnt_next    = cnt_reg + bsg_pkg::cnt_t'(push) - bsg_pkg::cnt_t'(item_done);
        resv_next   = resv_reg + bsg_pkg::cnt_t'(reserve) - bsg_pkg::cnt_t'(item_done);
        phase_next  = phase_reg;
        if (beat)
        begin
            phase_next = !item_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            resv_reg   <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            resv_reg   <= resv_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

// ===== src/boosted_saturated_gradient_core.sv =====
// A result beat is registered first in the scan stage and then in the output queue before it is offered.
// Throughput: one pixel per cycle while the output queue has room and no configuration write
// holds off input; on the last row each pixel gives two result beats, so there the output port sets the rate.
// A configuration write holds off input for the following cycle.
// Reset (rst_n, asynchronous, active low) clears registers, position and queue;
// the three line store memories are not cleared and hold stale data until written.
`default_nettype none

module boosted_saturated_gradient_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [bsg_pkg::PIX_W-1:0]          s_axis_tdata,   // [7:0] pixel_value
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [bsg_pkg::OUT_DATA_W-1:0]          m_axis_tdata,   // [7:0] grad_x, [15:8] grad_y
    output logic                                    m_axis_tuser,   // [0] frame_end
    output logic                                    m_axis_tlast,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bsg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bsg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    bsg_pkg::cfg_t  cfg_reg, cfg_next;
    bsg_pkg::calc_t calc;
    bsg_pkg::item_t item;
    logic           cfg_hold_reg, cfg_hold_next;
    logic           accept, has_res, room, push;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = room && !cfg_hold_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_hold_next = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                bsg_pkg::REG_IMAGE_WIDTH:  cfg_next.image_width      = cfg_data[bsg_pkg::IMG_W_W-1:0];
                bsg_pkg::REG_IMAGE_HEIGHT: cfg_next.image_height     = cfg_data[bsg_pkg::ROW_W-1:0];
                bsg_pkg::REG_SAT_LIMIT:    cfg_next.saturation_limit = cfg_data[bsg_pkg::SAT_W-1:0];
                bsg_pkg::REG_BOOST_GAIN:   cfg_next.boost_gain       = cfg_data[bsg_pkg::GAIN_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width      <= bsg_pkg::WIDTH_RST;
            cfg_reg.image_height     <= bsg_pkg::HEIGHT_RST;
            cfg_reg.saturation_limit <= bsg_pkg::SAT_RST;
            cfg_reg.boost_gain       <= bsg_pkg::GAIN_RST;
            cfg_hold_reg             <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            cfg_hold_reg <= cfg_hold_next;
        end
    end

    bsg_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .pixel  (s_axis_tdata),
        .cfg    (cfg_reg),
        .has_res(has_res),
        .calc   (calc)
    );

    bsg_boost u_boost (
        .calc(calc),
        .gain(cfg_reg.boost_gain),
        .push(push),
        .item(item)
    );

    bsg_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .reserve      (accept && has_res),
        .push         (push),
        .item         (item),
        .room         (room),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== src/bsg_checker.sv =====
`default_nettype none

module bsg_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_axis_tready,
    input wire logic                               cfg_valid,
    input wire logic                               cfg_ready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [bsg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input wire logic                               m_axis_tuser,
    input wire logic                               m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    a_frame_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("frame end on a non-final or nonzero beat");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tlast && (m_axis_tdata == '0))
        else $error("second beat of a pair missing or not zero");

    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_axis_tready)
        else $error("input taken right after a register write");

endmodule

bind boosted_saturated_gradient_core bsg_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_ITEMS  = 1600;
    localparam int CALM_ITEMS    = 160;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 50;

    typedef struct packed {
        bsg_pkg::pix_t grad_x;
        bsg_pkg::pix_t grad_y;
        logic          frame_end;
        logic          run_last;
    } grad_beat_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [bsg_pkg::PIX_W-1:0]           s_axis_tdata = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [bsg_pkg::OUT_DATA_W-1:0]      m_axis_tdata;
    logic                                m_axis_tuser;
    logic                                m_axis_tlast;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [bsg_pkg::CFG_ADDR_W-1:0]      cfg_addr = '0;
    logic [bsg_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

    logic [bsg_pkg::IMG_W_W-1:0]         cfg_width = bsg_pkg::WIDTH_RST;
    logic [bsg_pkg::ROW_W-1:0]           cfg_height = bsg_pkg::HEIGHT_RST;
    logic [bsg_pkg::SAT_W-1:0]           cfg_sat = bsg_pkg::SAT_RST;
    logic [bsg_pkg::GAIN_W-1:0]          cfg_gain = bsg_pkg::GAIN_RST;

    bsg_pkg::pix_t                       line_prev2 [bsg_pkg::MAX_WIDTH];
    bsg_pkg::pix_t                       line_prev1 [bsg_pkg::MAX_WIDTH];
    bsg_pkg::pix_t                       win_left = '0;
    bsg_pkg::pix_t                       win_mid = '0;
    int                                  row_pos = 0;
    int                                  col_pos = 0;

    grad_beat_t                          pending_grads [$];
    grad_beat_t                          head_beat;
    int                                  mismatches = 0;
    int                                  beat_count = 0;
    int                                  cycle_count = 0;
    int                                  stall_left = 0;
    bit                                  calm = 1'b0;

    boosted_saturated_gradient_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bsg_pkg::pix_t boost_clamp(input int diff);
        int s;
        int m;
        int v;
        int p;
        s = int'(cfg_sat);
        m = (diff < s) ? diff : s;
        v = s + m;
        if (v < 0)
            v = 0;
        p = v * int'(cfg_gain);
        return (p > 255) ? bsg_pkg::PIX_MAX : bsg_pkg::pix_t'(p);
    endfunction

    function automatic void predict_pixel(input bsg_pkg::pix_t px);
        int            w;
        int            h;
        int            c;
        int            r;
        bsg_pkg::pix_t above;
        bsg_pkg::pix_t mid;
        bsg_pkg::pix_t gx;
        bsg_pkg::pix_t gy;
        bit            lc;
        bit            lr;
        w = int'(cfg_width);
        if (w < 3)
            w = 3;
        if (w > bsg_pkg::MAX_WIDTH)
            w = bsg_pkg::MAX_WIDTH;
        h = int'(cfg_height);
        if (h < 3)
            h = 3;
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = row_pos;
        lc = (c + 1 >= w);
        lr = (r + 1 >= h);
        above = line_prev2[c];
        mid = line_prev1[c];
        win_left = win_mid;
        win_mid = mid;
        if (r == 0 && !lr)
        begin
            pending_grads.push_back({8'd0, 8'd0, 1'b0, 1'b1});
        end
        else if (r >= 2)
        begin
            gx = '0;
            gy = '0;
            if (c != 0 && !lc)
            begin
                gx = boost_clamp(int'(line_prev1[c + 1]) - int'(win_left));
                gy = boost_clamp(int'(px) - int'(above));
            end
            pending_grads.push_back({gx, gy, 1'b0, ~lr});
            if (lr)
                pending_grads.push_back({8'd0, 8'd0, lc, 1'b1});
        end
        else if (lr)
        begin
            pending_grads.push_back({8'd0, 8'd0, lc, 1'b1});
        end
        line_prev2[c] = mid;
        line_prev1[c] = px;
        if (lc)
        begin
            col_pos = 0;
            row_pos = lr ? 0 : ((r + 1) & 16'hFFFF);
        end
        else
        begin
            col_pos = c + 1;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch %s at beat %0d: got %h, want %h", what, beat_count, got, want);
    endtask

    task automatic send_pixel(input bsg_pkg::pix_t px);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = int'($urandom_range(1, 8));
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_pixel(px);
    endtask

    task automatic send_run3(input bsg_pkg::pix_t p0, input bsg_pkg::pix_t p1,
                             input bsg_pkg::pix_t p2);
        send_pixel(p0);
        send_pixel(p1);
        send_pixel(p2);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_grads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input bsg_pkg::cfg_reg_t idx,
                             input logic [bsg_pkg::CFG_DATA_W-1:0] word);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            bsg_pkg::REG_IMAGE_WIDTH:  cfg_width = word[bsg_pkg::IMG_W_W-1:0];
            bsg_pkg::REG_IMAGE_HEIGHT: cfg_height = word[bsg_pkg::ROW_W-1:0];
            bsg_pkg::REG_SAT_LIMIT:    cfg_sat = word[bsg_pkg::SAT_W-1:0];
            bsg_pkg::REG_BOOST_GAIN:   cfg_gain = word[bsg_pkg::GAIN_W-1:0];
            default:                   ;
        endcase
        @(posedge clk);
    endtask

    // reset gain and limit; shrink the frame after two row-0 pixels
    task automatic test_reset_defaults();
        send_pixel(8'hFF);
        send_pixel(8'h00);
        wait_idle();
        write_reg(bsg_pkg::REG_IMAGE_WIDTH, 16'd3);
        write_reg(bsg_pkg::REG_IMAGE_HEIGHT, 16'd3);
        send_pixel(8'h80);
        send_run3(8'hFF, 8'h55, 8'h00);
        send_run3(8'hAA, 8'hFF, 8'h0F);
        wait_idle();
    endtask

    // sizes below the minimum, full limit and gain, ignored upper data bits
    task automatic test_extreme_settings();
        write_reg(bsg_pkg::REG_IMAGE_WIDTH, 16'hF002);
        write_reg(bsg_pkg::REG_IMAGE_HEIGHT, 16'h0000);
        write_reg(bsg_pkg::REG_SAT_LIMIT, 16'hFFFF);
        write_reg(bsg_pkg::REG_BOOST_GAIN, 16'hFFFF);
        send_run3(8'h00, 8'hFF, 8'h00);
        send_run3(8'h00, 8'h12, 8'hFF);
        send_run3(8'h34, 8'h00, 8'h56);
        wait_idle();
    endtask

    // width above the maximum, then column and row beyond a reduced size
    task automatic test_reduced_size();
        write_reg(bsg_pkg::REG_IMAGE_WIDTH, 16'h0FFF);
        write_reg(bsg_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
        write_reg(bsg_pkg::REG_SAT_LIMIT, 16'd8);
        write_reg(bsg_pkg::REG_BOOST_GAIN, 16'd2);
        send_run3(8'h10, 8'h20, 8'h30);
        send_pixel(8'h40);
        wait_idle();
        write_reg(bsg_pkg::REG_IMAGE_WIDTH, 16'd3);
        send_pixel(8'h50);
        send_run3(8'h60, 8'h05, 8'hF0);
        send_run3(8'h70, 8'h80, 8'h90);
        wait_idle();
        write_reg(bsg_pkg::REG_IMAGE_HEIGHT, 16'd3);
        send_run3(8'hA0, 8'hB0, 8'hC0);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int                             sent;
        int                             n;
        int                             w;
        int                             h;
        int                             weff;
        int                             change_at;
        int                             style;
        int                             base;
        int                             spread;
        int                             v;
        bsg_pkg::pix_t                  px;
        logic [bsg_pkg::CFG_DATA_W-1:0] word;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            case ($urandom_range(0, 9))
                0:       w = int'($urandom_range(0, 2));
                1:       w = int'($urandom_range(17, 40));
                default: w = int'($urandom_range(3, 16));
            endcase
            h = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 2))
                                            : int'($urandom_range(3, 6));
            word = 16'($urandom);
            word[bsg_pkg::IMG_W_W-1:0] = w[bsg_pkg::IMG_W_W-1:0];
            write_reg(bsg_pkg::REG_IMAGE_WIDTH, word);
            write_reg(bsg_pkg::REG_IMAGE_HEIGHT, 16'(h));
            word = 16'($urandom);
            case ($urandom_range(0, 5))
                0:       word[bsg_pkg::SAT_W-1:0] = 8'd0;
                1:       word[bsg_pkg::SAT_W-1:0] = 8'd255;
                2:       word[bsg_pkg::SAT_W-1:0] = 8'($urandom_range(0, 255));
                default: word[bsg_pkg::SAT_W-1:0] = 8'($urandom_range(0, 24));
            endcase
            write_reg(bsg_pkg::REG_SAT_LIMIT, word);
            word = 16'($urandom);
            case ($urandom_range(0, 5))
                0:       word[bsg_pkg::GAIN_W-1:0] = 8'd0;
                1:       word[bsg_pkg::GAIN_W-1:0] = 8'd255;
                2:       word[bsg_pkg::GAIN_W-1:0] = 8'($urandom_range(0, 255));
                default: word[bsg_pkg::GAIN_W-1:0] = 8'($urandom_range(1, 8));
            endcase
            write_reg(bsg_pkg::REG_BOOST_GAIN, word);
            weff = (w < 3) ? 3 : w;
            change_at = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, weff * 3)) : -1;
            style = int'($urandom_range(0, 3));
            base = int'($urandom_range(0, 255));
            spread = int'($urandom_range(0, 40));
            n = 0;
            do
            begin
                // mid-frame: pause, narrow the row or move the last row
                if (n == change_at)
                begin
                    wait_idle();
                    case ($urandom_range(0, 2))
                        0: ;
                        1: write_reg(bsg_pkg::REG_IMAGE_WIDTH, 16'($urandom_range(0, weff)));
                        default: write_reg(bsg_pkg::REG_IMAGE_HEIGHT, 16'($urandom_range(0, 6)));
                    endcase
                    weff = (cfg_width < 3) ? 3 : int'(cfg_width);
                end
                case (style)
                    0: px = bsg_pkg::pix_t'($urandom_range(0, 255));
                    3: px = $urandom_range(0, 1) ? bsg_pkg::PIX_MAX : bsg_pkg::pix_t'(0);
                    default:
                    begin
                        v = base + int'($urandom_range(0, 2 * spread)) - spread;
                        if (v < 0)
                            v = 0;
                        if (v > 255)
                            v = 255;
                        px = bsg_pkg::pix_t'(v);
                    end
                endcase
                calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
                send_pixel(px);
                n++;
                sent++;
            end
            while (row_pos != 0 || col_pos != 0);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0 && !calm)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= int'($urandom_range(0, 7));
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_grads.size() == 0)
            begin
                report_mismatch("unexpected beat", m_axis_tdata, 16'd0);
            end
            else
            begin
                head_beat = pending_grads.pop_front();
                if (m_axis_tdata[7:0] !== head_beat.grad_x)
                    report_mismatch("grad_x", 16'(m_axis_tdata[7:0]), 16'(head_beat.grad_x));
                if (m_axis_tdata[15:8] !== head_beat.grad_y)
                    report_mismatch("grad_y", 16'(m_axis_tdata[15:8]), 16'(head_beat.grad_y));
                if (m_axis_tuser !== head_beat.frame_end)
                    report_mismatch("frame_end", 16'(m_axis_tuser), 16'(head_beat.frame_end));
                if (m_axis_tlast !== head_beat.run_last)
                    report_mismatch("run_last", 16'(m_axis_tlast), 16'(head_beat.run_last));
            end
            beat_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_extreme_settings();
        test_reduced_size();
        test_random_frames();
        wait_idle();
        if (pending_grads.size() != 0)
            report_mismatch("leftover beats", 16'(pending_grads.size()), 16'd0);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
